>>> hdl/cdq_pkg.sv
// shared types and constants of the circular deque
`default_nettype none

package cdq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]         CAP_RESET = 5'd16;
  localparam logic signed [DATA_W-1:0] FAIL_DATA = -32'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_REAR  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_REAR  = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_t;

  typedef struct packed {
    logic ok;
    logic peek_hit;
    logic peek_miss;
    logic is_empty;
    logic is_full;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/cdq_if.sv
// channel interfaces of the circular deque
`default_nettype none

interface cdq_req_if;
  logic                              valid;
  logic                              ready;
  logic [cdq_pkg::OP_W-1:0]          opcode;
  logic signed [cdq_pkg::DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface cdq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [cdq_pkg::DATA_W-1:0] data;
  logic                              is_empty;
  logic                              is_full;

  modport source (output valid, output ok, output data, output is_empty, output is_full,
                  input ready);
  modport sink (input valid, input ok, input data, input is_empty, input is_full,
                output ready);
endinterface

interface cdq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cdq_pkg::CAP_W-1:0]  capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

>>> hdl/circular_deque.sv
// circular double-ended queue with a ring memory and a registered result
//
//   channel | role   | payload
//   --------+--------+-----------------------------------
//   req     | sink   | opcode, value
//   rsp     | source | ok, data, is_empty, is_full
//   cfg     | sink   | capacity (always ready)
//
// one transaction a cycle while req.ready is high; each request waits in the memory read
// stage and then moves to the output register, which drives rsp.valid
// req.ready drops only while the read stage holds a result that the stalled output
// register cannot take
// synchronous reset empties the queue and sets capacity to 16; slot contents are kept
`default_nettype none

module circular_deque #(
  parameter int DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  cdq_req_if.sink       req,
  cdq_rsp_if.source     rsp,
  cdq_cfg_if.sink       cfg
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > cdq_pkg::CAP_W) ? CNT_W : cdq_pkg::CAP_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic signed [cdq_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [cdq_pkg::DATA_W-1:0] rd_data;

  logic [PTR_W-1:0]         head, head_next;
  logic [PTR_W-1:0]         tail, tail_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [cdq_pkg::CAP_W-1:0] capacity;

  logic                     pend;
  cdq_pkg::result_t         pend_res, res;
  logic                     out_valid;

  logic [CMP_W-1:0]         cap_eff;
  logic                     empty, full;
  logic                     wr_en;
  logic [PTR_W-1:0]         wr_addr, rd_addr;
  logic                     in_fire, move;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
    return (i == LAST) ? '0 : i + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] i);
    return (i == '0) ? LAST : i - PTR_W'(1);
  endfunction

  assign move    = pend && (!out_valid || rsp.ready);
  assign req.ready = !pend || move;
  assign in_fire = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  assign empty = (count == '0);
  assign full  = (CMP_W'(count) >= cap_eff);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = tail;
    rd_addr    = head;
    res        = '0;
    unique case (req.opcode)
      cdq_pkg::OP_INS_FRONT: begin
        if (!full) begin
          head_next  = ring_prev(head);
          wr_en      = 1'b1;
          wr_addr    = ring_prev(head);
          count_next = count + CNT_W'(1);
          res.ok     = 1'b1;
        end
      end
      cdq_pkg::OP_INS_REAR: begin
        if (!full) begin
          tail_next  = ring_next(tail);
          wr_en      = 1'b1;
          wr_addr    = tail;
          count_next = count + CNT_W'(1);
          res.ok     = 1'b1;
        end
      end
      cdq_pkg::OP_REM_FRONT: begin
        if (!empty) begin
          head_next  = ring_next(head);
          count_next = count - CNT_W'(1);
          res.ok     = 1'b1;
        end
      end
      cdq_pkg::OP_REM_REAR: begin
        if (!empty) begin
          tail_next  = ring_prev(tail);
          count_next = count - CNT_W'(1);
          res.ok     = 1'b1;
        end
      end
      cdq_pkg::OP_PEEK_FRONT: begin
        rd_addr       = head;
        res.ok        = !empty;
        res.peek_hit  = !empty;
        res.peek_miss = empty;
      end
      cdq_pkg::OP_PEEK_REAR: begin
        rd_addr       = ring_prev(tail);
        res.ok        = !empty;
        res.peek_hit  = !empty;
        res.peek_miss = empty;
      end
      default: begin
      end
    endcase
    res.is_empty = (count_next == '0);
    res.is_full  = (CMP_W'(count_next) >= cap_eff);
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (in_fire && wr_en) begin
      mem[wr_addr] <= req.value;
    end
    if (in_fire) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      capacity <= cdq_pkg::CAP_RESET;
      pend     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.capacity;
      end
      if (in_fire) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
      if (in_fire) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_res <= res;
    end
    if (move) begin
      rsp.ok       <= pend_res.ok;
      rsp.is_empty <= pend_res.is_empty;
      rsp.is_full  <= pend_res.is_full;
      if (pend_res.peek_hit) begin
        rsp.data <= rd_data;
      end else if (pend_res.peek_miss) begin
        rsp.data <= cdq_pkg::FAIL_DATA;
      end else begin
        rsp.data <= '0;
      end
    end
  end

  assign rsp.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(count) <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    in_fire && wr_en |=> count == $past(count) + CNT_W'(1))
    else $error("successful insert did not grow the count");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    pend && !move |=> pend && $stable(pend_res))
    else $error("read stage lost its result under stall");

  a_ready_only_when_free: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> pend && out_valid && !rsp.ready)
    else $error("request side stalled without a blocked result");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the circular deque, scored against a built-in deque model
`default_nettype none

module testbench;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [cdq_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [cdq_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic                       ok;
    logic [cdq_pkg::DATA_W-1:0] data;
    logic                       is_empty;
    logic                       is_full;
  } deque_result_t;

  class deque_scoreboard;
    deque_result_t              expected_replies[$];
    logic [cdq_pkg::DATA_W-1:0] ring[DEPTH];
    logic [IDX_W-1:0]           head;
    logic [IDX_W-1:0]           tail;
    logic [cdq_pkg::CAP_W-1:0]  count;
    logic [cdq_pkg::CAP_W-1:0]  capacity;
    int unsigned                mismatch_count;

    function new();
      head = '0;
      tail = '0;
      count = '0;
      capacity = cdq_pkg::CAP_RESET;
      mismatch_count = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
    endtask

    // one accepted request: update the deque and queue the reply it causes
    function void accept_request(logic [cdq_pkg::OP_W-1:0] opcode,
                                 logic [cdq_pkg::DATA_W-1:0] value);
      deque_result_t             reply;
      logic [cdq_pkg::CAP_W-1:0] limit;
      logic [IDX_W-1:0]          last;
      logic                      was_empty;
      logic                      was_full;
      limit = (capacity == 0) ? cdq_pkg::CAP_W'(1) :
              (capacity > DEPTH) ? cdq_pkg::CAP_W'(DEPTH) : capacity;
      was_empty = (count == 0);
      was_full = (count >= limit);
      reply.ok = 1'b0;
      reply.data = '0;
      case (opcode)
        cdq_pkg::OP_INS_FRONT: if (!was_full) begin
          head = head - 1'b1;
          ring[head] = value;
          count = count + 1'b1;
          reply.ok = 1'b1;
        end
        cdq_pkg::OP_INS_REAR: if (!was_full) begin
          ring[tail] = value;
          tail = tail + 1'b1;
          count = count + 1'b1;
          reply.ok = 1'b1;
        end
        cdq_pkg::OP_REM_FRONT: if (!was_empty) begin
          head = head + 1'b1;
          count = count - 1'b1;
          reply.ok = 1'b1;
        end
        cdq_pkg::OP_REM_REAR: if (!was_empty) begin
          tail = tail - 1'b1;
          count = count - 1'b1;
          reply.ok = 1'b1;
        end
        cdq_pkg::OP_PEEK_FRONT: if (!was_empty) begin
          reply.data = ring[head];
          reply.ok = 1'b1;
        end else begin
          reply.data = cdq_pkg::FAIL_DATA;
        end
        cdq_pkg::OP_PEEK_REAR: if (!was_empty) begin
          last = tail - 1'b1;
          reply.data = ring[last];
          reply.ok = 1'b1;
        end else begin
          reply.data = cdq_pkg::FAIL_DATA;
        end
        default: ;
      endcase
      reply.is_empty = (count == 0);
      reply.is_full = (count >= limit);
      expected_replies.push_back(reply);
    endfunction

    task check_result(logic ok, logic [cdq_pkg::DATA_W-1:0] data, logic is_empty,
                      logic is_full);
      deque_result_t want;
      if (expected_replies.size() == 0) begin
        report("result with no transaction pending");
        return;
      end
      want = expected_replies.pop_front();
      if (ok !== want.ok) report($sformatf("ok %0b, expected %0b", ok, want.ok));
      if (data !== want.data)
        report($sformatf("data %0d, expected %0d", $signed(data), $signed(want.data)));
      if (is_empty !== want.is_empty)
        report($sformatf("is_empty %0b, expected %0b", is_empty, want.is_empty));
      if (is_full !== want.is_full)
        report($sformatf("is_full %0b, expected %0b", is_full, want.is_full));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  cdq_req_if req_ch();
  cdq_rsp_if rsp_ch();
  cdq_cfg_if cfg_ch();

  deque_scoreboard tracker = new();

  circular_deque #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      tracker.check_result(rsp_ch.ok, rsp_ch.data, rsp_ch.is_empty, rsp_ch.is_full);
  end

  task automatic send_item(logic [cdq_pkg::OP_W-1:0] opcode,
                           logic [cdq_pkg::DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= opcode;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.accept_request(opcode, value);
  endtask

  // stop sending and wait until every reply is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [cdq_pkg::CAP_W-1:0] cap);
    cfg_ch.valid <= 1'b1;
    cfg_ch.capacity <= cap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    tracker.capacity = cap;
  endtask

  initial begin
    logic [cdq_pkg::CAP_W-1:0]  caps[10];
    logic [cdq_pkg::OP_W-1:0]   op;
    logic [cdq_pkg::DATA_W-1:0] val;
    int unsigned                pick;
    int                         run_left;
    bit                         filling;
    caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd16, 5'd5, 5'd31};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.capacity = '0;
    send_idle_pct = 25;
    recv_idle_pct = 51;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty queue: failing peeks and removes, spare opcodes, then inserts at both ends, peeks and removes
    send_item(cdq_pkg::OP_PEEK_FRONT, 32'h1234_5678);
    send_item(cdq_pkg::OP_PEEK_REAR, '0);
    send_item(cdq_pkg::OP_REM_FRONT, '0);
    send_item(cdq_pkg::OP_REM_REAR, '0);
    send_item(OP_SPARE_A, 32'h5555_5555);
    send_item(OP_SPARE_B, '0);
    send_item(cdq_pkg::OP_INS_REAR, 32'h7fff_ffff);
    send_item(cdq_pkg::OP_INS_FRONT, 32'h8000_0000);
    send_item(cdq_pkg::OP_INS_REAR, 32'hffff_ffff);
    send_item(cdq_pkg::OP_INS_FRONT, '0);
    send_item(cdq_pkg::OP_PEEK_FRONT, '0);
    send_item(cdq_pkg::OP_PEEK_REAR, '0);
    send_item(OP_SPARE_B, 32'hffff_ffff);
    send_item(cdq_pkg::OP_REM_FRONT, '0);
    send_item(cdq_pkg::OP_REM_REAR, '0);
    send_item(cdq_pkg::OP_PEEK_FRONT, '0);
    send_item(cdq_pkg::OP_PEEK_REAR, '0);
    // capacity zero acts as one, two entries still held
    settle();
    write_capacity(5'd0);
    send_item(cdq_pkg::OP_INS_FRONT, 32'h0bad_cafe);
    send_item(cdq_pkg::OP_PEEK_REAR, '0);
    send_item(cdq_pkg::OP_REM_FRONT, '0);
    send_item(cdq_pkg::OP_REM_REAR, '0);
    send_item(cdq_pkg::OP_INS_REAR, 32'h0001_2345);
    send_item(cdq_pkg::OP_INS_FRONT, 32'h4321_0000);

    filling = 1'b1;
    run_left = 0;
    for (int seg = 0; seg < 10; seg++) begin
      settle();
      write_capacity(caps[seg]);
      if (seg < 4) begin
        send_idle_pct = 25;
        recv_idle_pct = 51;
      end else if (seg < 7) begin
        send_idle_pct = 51;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < 75; i++) begin
        // alternate runs that favor filling and draining
        if (run_left == 0) begin
          filling = !filling;
          run_left = $urandom_range(8, 40);
        end
        run_left--;
        pick = $urandom_range(99);
        if (pick < 4)
          op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
        else if (pick < (filling ? 50 : 30))
          op = $urandom_range(1) ? cdq_pkg::OP_INS_FRONT : cdq_pkg::OP_INS_REAR;
        else if (pick < (filling ? 75 : 70))
          op = $urandom_range(1) ? cdq_pkg::OP_REM_FRONT : cdq_pkg::OP_REM_REAR;
        else
          op = $urandom_range(1) ? cdq_pkg::OP_PEEK_FRONT : cdq_pkg::OP_PEEK_REAR;
        case ($urandom_range(7))
          0: val = 32'h7fff_ffff;
          1: val = 32'h8000_0000;
          2: val = '0;
          3: val = 32'hffff_ffff;
          default: val = $urandom;
        endcase
        send_item(op, val);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.expected_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
